[src/blpm_pkg.sv]
// Package: shared types, constants and base decode helper for the barcode matcher
`timescale 1ns / 1ps

package blpm_pkg;

    // table size and field widths
    localparam int MAX_SAMPLES = 64;
    localparam int MAX_LEN     = 16;
    localparam int SLOT_W      = 6;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int CODE_BASES  = CODE_W / 2;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BASE = 1'b1;

    // ascii characters of the four bases
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

    // 2-bit base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_T = 2'd1;
    localparam logic [1:0] BASE_C = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             restart;
        logic             step;
        logic             base_ok;
        logic [1:0]       base;
        logic [LEN_W-1:0] pos;
    } bcast_t;

    // best candidate passed along the chain
    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] slot;
    } cand_t;

    // base held at a given index of a packed code, zero past the code
    function automatic logic [1:0] base_at(input logic [CODE_W-1:0] code,
                                           input logic [LEN_W-1:0]  idx);
        logic [1:0] res;
        res = 2'd0;
        for (int k = 0; k < CODE_BASES; k++) begin
            if (idx == LEN_W'(k)) begin
                res = code[2*k +: 2];
            end
        end
        return res;
    endfunction

endpackage

[src/blpm_cell.sv]
// Cell: one barcode table slot with its match state and one chain stage
`timescale 1ns / 1ps

module blpm_cell
    import blpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] slot_id,
    input  logic              load_en,
    input  logic [CODE_W-1:0] load_code,
    input  logic [LEN_W-1:0]  load_length,
    input  bcast_t            bc,
    input  cand_t             chain_in,
    output cand_t             chain_out
);

    logic [CODE_W-1:0] code_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              match_reg;
    logic              match_next;
    logic              hit_reg;
    logic              hit_next;
    cand_t             cand_reg;
    cand_t             cand_next;

    logic              active;
    logic [LEN_W-1:0]  idx;
    logic [1:0]        want;

    // compare this slot's base at the current read position
    always_comb
    begin
        active = bc.step && (len_reg != '0) && (bc.pos < len_reg) && match_reg;
        idx    = LEN_W'(len_reg - bc.pos - LEN_W'(1));
        want   = base_at(code_reg, idx);
    end

    // next state of the slot
    always_comb
    begin
        len_next   = load_en ? load_length : len_reg;
        match_next = match_reg;
        hit_next   = hit_reg;
        if (bc.restart) begin
            match_next = 1'b1;
            hit_next   = 1'b0;
        end else if (active) begin
            if (!bc.base_ok || (bc.base != want)) begin
                match_next = 1'b0;
            end else if ((bc.pos + LEN_W'(1)) == len_reg) begin
                hit_next = 1'b1;
            end
        end
    end

    // keep the better of the incoming candidate and this slot
    always_comb
    begin
        if (hit_reg && (!chain_in.found || (len_reg >= chain_in.len))) begin
            cand_next.found = 1'b1;
            cand_next.len   = len_reg;
            cand_next.slot  = slot_id;
        end else begin
            cand_next = chain_in;
        end
    end

    // barcode code storage
    always_ff @(posedge clk)
    begin
        if (load_en) begin
            code_reg <= load_code;
        end
    end

    // chain stage
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg   <= '0;
            match_reg <= 1'b1;
            hit_reg   <= 1'b0;
        end else begin
            len_reg   <= len_next;
            match_reg <= match_next;
            hit_reg   <= hit_next;
        end
    end

    assign chain_out = cand_reg;

endmodule

[src/barcode_longest_prefix_match.sv]
// Top level: read index intake, cell row and result scan control
// Result: a final base starts a scan of the best candidate along the cell chain; the
// result word is registered once the scan is done and the output register is free.
// Throughput: one load or base per cycle while idle; a final base holds off input for the
// scan, one cell per cycle, and while the previous result still waits for out_ready.
// Reset: all slots empty, read state cleared, no result pending.
`timescale 1ns / 1ps

module barcode_longest_prefix_match
    import blpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [SLOT_W-1:0] entry_slot,
    input  logic [CODE_W-1:0] entry_code,
    input  logic [LEN_W-1:0]  entry_length,
    input  logic [CHAR_W-1:0] base_char,
    input  logic              last_base,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] sample_number,
    output logic              undetermined
);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  pos_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SLOT_W-1:0] sample_reg;
    logic              undet_reg;

    logic              accept;
    logic              scan_done;
    logic              capture;
    logic              final_base;
    logic [LEN_W-1:0]  sat_length;
    bcast_t            bc;
    cand_t             chain [MAX_SAMPLES+1];

    // input handshake and command decode
    always_comb
    begin
        accept     = in_valid && in_ready;
        final_base = accept && (op == OP_BASE) && last_base;
        scan_done  = (cnt_reg == CNT_W'(MAX_SAMPLES));
        capture    = ((state_reg == ST_SCAN && scan_done) || state_reg == ST_HOLD)
                     && (!out_valid_reg || out_ready);
        sat_length = (entry_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : entry_length;
    end

    // broadcast to the cells
    always_comb
    begin
        bc.restart = (accept && (op == OP_LOAD)) || capture;
        bc.step    = accept && (op == OP_BASE) && (pos_reg < LEN_W'(MAX_LEN));
        bc.pos     = pos_reg;
        bc.base_ok = 1'b1;
        case (base_char)
            CHAR_A:  bc.base = BASE_A;
            CHAR_T:  bc.base = BASE_T;
            CHAR_C:  bc.base = BASE_C;
            CHAR_G:  bc.base = BASE_G;
            default:
            begin
                bc.base    = BASE_A;
                bc.base_ok = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (final_base) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done) begin
                    state_next = capture ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (capture) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_SCAN: in_ready = 1'b0;
            ST_HOLD: in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    // scan counter, read position and output valid
    always_comb
    begin
        if (state_reg != ST_SCAN) begin
            cnt_next = '0;
        end else if (!scan_done) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end

        if (bc.restart) begin
            pos_next = '0;
        end else if (bc.step) begin
            pos_next = pos_reg + LEN_W'(1);
        end else begin
            pos_next = pos_reg;
        end

        if (capture) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // row of slot cells, chain runs from slot 0 upward
    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        blpm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .slot_id     (SLOT_W'(i)),
            .load_en     (accept && (op == OP_LOAD) && (entry_slot == SLOT_W'(i))),
            .load_code   (entry_code),
            .load_length (sat_length),
            .bc          (bc),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1])
        );
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (capture) begin
            sample_reg <= chain[MAX_SAMPLES].found ? chain[MAX_SAMPLES].slot : '0;
            undet_reg  <= !chain[MAX_SAMPLES].found;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_number = sample_reg;
    assign undetermined  = undet_reg;

endmodule
